// ===== hw/rtl/steg_pkg.sv =====
// Shared constants, codes and control types of the square tone envelope generator.
package steg_pkg;

	localparam int SAMPLE_RATE = 44100;
	localparam int MS_PER_S    = 1000;

	localparam int FREQ_W   = 15;
	localparam int DUR_W    = 12;
	localparam int AMP_W    = 15;
	localparam int GAP_W    = 10;
	localparam int FADE_W   = 8;
	localparam int SAMPLE_W = 16;
	localparam int LEN_W    = 18;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W    = 15;

	localparam int DUR_MAX = (1 << DUR_W) - 1;
	localparam int LEN_MAX = (1 << LEN_W) - 1;

	// 44100 / 1000 = 44 + 1/10; the tenth is taken by reciprocal multiply,
	// exact for every 12-bit duration.
	localparam int LEN_WHOLE   = SAMPLE_RATE / MS_PER_S;
	localparam int TENTH_MUL   = 3277;
	localparam int TENTH_SHIFT = 15;

	localparam int SR_W    = $clog2(SAMPLE_RATE + 1);
	localparam int MUL_AW  = AMP_W;
	localparam int PROD_W  = MUL_AW + SR_W;
	localparam int DIV_NW  = AMP_W + FADE_W;
	localparam int DIV_CW  = $clog2(DIV_NW + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FADE  = 2'd2;

	localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd7864;
	localparam logic [GAP_W-1:0]  GAP_RESET  = 10'd529;
	localparam logic [FADE_W-1:0] FADE_RESET = 8'd220;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_TONE = 2'd1,
		MODE_GAP  = 2'd2
	} play_mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ST_MUL,
		S_ST_LEN,
		S_TK_MUL,
		S_TK_DIV,
		S_TK_WAIT,
		S_TK_EMIT
	} ctrl_state_t;

	typedef enum logic {
		MUL_LEN,
		MUL_AMP
	} mul_op_t;

	typedef struct packed {
		logic    cap;
		logic    mul_en;
		mul_op_t mul_op;
		logic    div_load;
		logic    tone_load;
		logic    emit;
	} steg_cmd_t;

	typedef struct packed {
		logic mode_tone;
		logic div_done;
		logic res_free;
	} steg_sts_t;

endpackage

// ===== hw/rtl/steg_ctrl.sv =====
// Controller state machine: sequences start loading and sample ticks.
module steg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                action,
	output logic                req_stall,
	input  steg_pkg::steg_sts_t sts,
	output steg_pkg::steg_cmd_t cmd
);
	import steg_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (action == ACT_START) begin
						state_nxt = S_ST_MUL;
					end else if (sts.mode_tone) begin
						state_nxt = S_TK_MUL;
					end else begin
						state_nxt = S_TK_EMIT;
					end
				end
			end
			S_ST_MUL:  state_nxt = S_ST_LEN;
			S_ST_LEN:  state_nxt = S_IDLE;
			S_TK_MUL:  state_nxt = S_TK_DIV;
			S_TK_DIV:  state_nxt = S_TK_WAIT;
			S_TK_WAIT: begin
				if (sts.div_done) begin
					state_nxt = S_TK_EMIT;
				end
			end
			S_TK_EMIT: begin
				if (sts.res_free) begin
					state_nxt = S_IDLE;
				end
			end
			default:   state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.mul_op = MUL_LEN;
		req_stall  = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				cmd.cap   = req_valid;
			end
			S_ST_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_LEN;
			end
			S_ST_LEN: begin
				cmd.tone_load = 1'b1;
			end
			S_TK_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_AMP;
			end
			S_TK_DIV: begin
				cmd.div_load = 1'b1;
			end
			S_TK_EMIT: begin
				cmd.emit = sts.res_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== hw/rtl/steg_dp.sv =====
// Datapath: config registers, tone state, shared multiplier, serial divider, result register.
module steg_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [steg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [steg_pkg::CFG_W-1:0]            cfg_data,
	input  logic [steg_pkg::FREQ_W-1:0]           frequency,
	input  logic [steg_pkg::DUR_W-1:0]            duration_ms,
	input  logic                                  last_tone,
	input  steg_pkg::steg_cmd_t                   cmd,
	output steg_pkg::steg_sts_t                   sts,
	input  logic                                  res_stall,
	output logic                                  res_valid,
	output logic signed [steg_pkg::SAMPLE_W-1:0]  sample,
	output logic                                  active,
	output logic                                  segment_end
);
	import steg_pkg::*;

	logic [AMP_W-1:0]  amp_q;
	logic [GAP_W-1:0]  gap_cfg_q;
	logic [FADE_W-1:0] max_fade_q;

	logic [FREQ_W-1:0] freq_q;
	logic [DUR_W-1:0]  dur_q;
	logic              last_q;

	logic [PROD_W-1:0] prod_q;
	logic [SR_W-1:0]   rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [SR_W-1:0]   dvs_q;
	logic [DIV_CW-1:0] cnt_q;

	logic [SR_W-1:0]   phase_q;
	logic [LEN_W-1:0]  idx_q;
	logic [LEN_W-1:0]  len_q;
	logic [FADE_W-1:0] fade_q;
	logic [SR_W-1:0]   tfreq_q;
	logic [GAP_W-1:0]  gap_left_q;
	play_mode_t        mode_q;
	logic              gap_pend_q;

	logic                       res_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       active_q;
	logic                       seg_q;

	logic [LEN_W-1:0]  rem_len;
	logic [LEN_W-1:0]  near;
	logic [FADE_W-1:0] num;
	logic [MUL_AW-1:0] mul_a;
	logic [SR_W-1:0]   mul_b;
	logic [SR_W:0]     shifted;
	logic              div_ge;
	logic [LEN_W:0]    len_raw;
	logic [LEN_W-1:0]  len_new;
	logic [LEN_W-3:0]  len4;
	logic [FADE_W-1:0] fade_min;
	logic [FADE_W-1:0] fade_new;
	logic [SR_W-1:0]   freq_mod;
	logic [AMP_W-1:0]  mag;
	logic              positive;
	logic [SR_W:0]     psum;
	logic [SR_W-1:0]   phase_nxt;
	logic signed [SAMPLE_W-1:0] tone_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q      <= AMP_RESET;
			gap_cfg_q  <= GAP_RESET;
			max_fade_q <= FADE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_AMPLITUDE: amp_q      <= cfg_data[AMP_W-1:0];
				CFG_GAP:       gap_cfg_q  <= cfg_data[GAP_W-1:0];
				CFG_MAX_FADE:  max_fade_q <= cfg_data[FADE_W-1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			freq_q <= frequency;
			dur_q  <= duration_ms;
			last_q <= last_tone;
		end
	end

	assign rem_len = len_q - idx_q - LEN_W'(1);
	assign near    = (idx_q < rem_len) ? idx_q : rem_len;
	assign num     = (near < LEN_W'(fade_q)) ? near[FADE_W-1:0] : fade_q;

	always_comb begin
		case (cmd.mul_op)
			MUL_LEN: begin
				mul_a = MUL_AW'(dur_q);
				mul_b = SR_W'(TENTH_MUL);
			end
			MUL_AMP: begin
				mul_a = amp_q;
				mul_b = SR_W'(num);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
	end

	assign shifted = {rem_q, quo_q[DIV_NW-1]};
	assign div_ge  = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_load) begin
			cnt_q <= DIV_CW'(DIV_NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - DIV_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= '0;
			quo_q <= prod_q[DIV_NW-1:0];
			dvs_q <= SR_W'(fade_q);
		end else if (cnt_q != '0) begin
			rem_q <= div_ge ? SR_W'(shifted - {1'b0, dvs_q}) : shifted[SR_W-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], div_ge};
		end
	end

	always_comb begin
		len_raw = (LEN_W+1)'(dur_q) * (LEN_W+1)'(LEN_WHOLE) +
			(LEN_W+1)'(prod_q[PROD_W-1:TENTH_SHIFT]);
		if (len_raw > (LEN_W+1)'(LEN_MAX)) begin
			len_new = LEN_W'(LEN_MAX);
		end else if (len_raw == '0) begin
			len_new = LEN_W'(1);
		end else begin
			len_new = len_raw[LEN_W-1:0];
		end
		len4     = len_new[LEN_W-1:2];
		fade_min = (len4 < (LEN_W-2)'(max_fade_q)) ? len4[FADE_W-1:0] : max_fade_q;
		fade_new = (fade_min == '0) ? FADE_W'(1) : fade_min;
	end

	assign freq_mod    = (SR_W'(freq_q) >= SR_W'(SAMPLE_RATE)) ?
		SR_W'(freq_q) - SR_W'(SAMPLE_RATE) : SR_W'(freq_q);
	assign mag         = quo_q[AMP_W-1:0];
	assign positive    = phase_q < SR_W'(SAMPLE_RATE / 2);
	assign tone_sample = positive ? $signed(SAMPLE_W'(mag)) : -$signed(SAMPLE_W'(mag));
	assign psum        = (SR_W+1)'(phase_q) + (SR_W+1)'(tfreq_q);
	assign phase_nxt   = (psum >= (SR_W+1)'(SAMPLE_RATE)) ?
		SR_W'(psum - (SR_W+1)'(SAMPLE_RATE)) : psum[SR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			idx_q      <= '0;
			len_q      <= '0;
			fade_q     <= FADE_W'(1);
			tfreq_q    <= '0;
			gap_left_q <= '0;
			mode_q     <= MODE_IDLE;
			gap_pend_q <= 1'b0;
		end else begin
			if (cmd.tone_load) begin
				len_q      <= len_new;
				fade_q     <= fade_new;
				tfreq_q    <= freq_mod;
				phase_q    <= '0;
				idx_q      <= '0;
				gap_left_q <= last_q ? '0 : gap_cfg_q;
				gap_pend_q <= !last_q && (gap_cfg_q != '0);
				mode_q     <= MODE_TONE;
			end else if (cmd.emit) begin
				case (mode_q)
					MODE_TONE: begin
						if (rem_len == '0) begin
							mode_q <= gap_pend_q ? MODE_GAP : MODE_IDLE;
						end else begin
							idx_q <= idx_q + LEN_W'(1);
						end
						phase_q <= phase_nxt;
					end
					MODE_GAP: begin
						if (gap_left_q <= GAP_W'(1)) begin
							gap_left_q <= '0;
							gap_pend_q <= 1'b0;
							mode_q     <= MODE_IDLE;
						end else begin
							gap_left_q <= gap_left_q - GAP_W'(1);
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (mode_q)
				MODE_TONE: begin
					sample_q <= tone_sample;
					active_q <= 1'b1;
					seg_q    <= (rem_len == '0) && !gap_pend_q;
				end
				MODE_GAP: begin
					sample_q <= '0;
					active_q <= 1'b1;
					seg_q    <= gap_left_q <= GAP_W'(1);
				end
				default: begin
					sample_q <= '0;
					active_q <= 1'b0;
					seg_q    <= 1'b0;
				end
			endcase
		end
	end

	assign sts.mode_tone = mode_q == MODE_TONE;
	assign sts.div_done  = cnt_q == '0;
	assign sts.res_free  = !res_valid_q || !res_stall;

	assign res_valid   = res_valid_q;
	assign sample      = sample_q;
	assign active      = active_q;
	assign segment_end = seg_q;

endmodule

// ===== hw/rtl/square_tone_envelope_generator.sv =====
// Top level of the square tone envelope generator: controller plus datapath.
//
//   channel   handshake              payload
//   request   req_valid / req_stall  action, frequency, duration_ms, last_tone
//   result    res_valid / res_stall  sample, active, segment_end
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A tone tick passes from request through the shared multiplier and the one-bit-per-cycle
// divider (23 steps) to the result register; idle and gap ticks skip the multiply and divide.
// Once a start request is taken, the tone is loaded: a constant multiply for the length,
// then fade, phase and gap setup.
// Reset clears control, config, tone, divider count and result-valid state at once; there is no clearing pass.
// A stalled result holds in the output register; the next request is taken meanwhile,
// and its tick completes once the result register frees.
module square_tone_envelope_generator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  logic                                  action,
	input  logic [steg_pkg::FREQ_W-1:0]           frequency,
	input  logic [steg_pkg::DUR_W-1:0]            duration_ms,
	input  logic                                  last_tone,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic signed [steg_pkg::SAMPLE_W-1:0]  sample,
	output logic                                  active,
	output logic                                  segment_end,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [steg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [steg_pkg::CFG_W-1:0]            cfg_data
);
	import steg_pkg::*;

	steg_cmd_t cmd;
	steg_sts_t sts;

	assign cfg_ready = 1'b1;

	steg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.action    (action),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	steg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.frequency   (frequency),
		.duration_ms (duration_ms),
		.last_tone   (last_tone),
		.cmd         (cmd),
		.sts         (sts),
		.res_stall   (res_stall),
		.res_valid   (res_valid),
		.sample      (sample),
		.active      (active),
		.segment_end (segment_end)
	);

endmodule

// ===== hw/rtl/steg_chk.sv =====
// Port-level checker for the square tone envelope generator, bound to the top level.
module steg_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               action,
	input logic               res_valid,
	input logic               res_stall,
	input logic signed [15:0] sample,
	input logic               active,
	input logic               segment_end
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !active |-> sample == 16'sd0 && !segment_end)
		else $error("idle result carries sample or segment end");

	a_seg_active: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && segment_end |-> active)
		else $error("segment end outside a tone or gap");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken before the first finished");

	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !action && !res_valid |=> !res_valid)
		else $error("start request produced a result");

endmodule

bind square_tone_envelope_generator steg_chk u_steg_chk (.*);

// ===== dv/square_tone_envelope_generator_tb.sv =====
// Self-checking testbench for the square tone envelope generator: tones, fades, gaps, registers.
module square_tone_envelope_generator_tb;
	import steg_pkg::*;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       active;
		logic                       segment_end;
	} tone_sample_t;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS  = 1250;
	localparam int PHASE_ITEMS   = 200;
	localparam int SETTLE_CYCLES = 100;
	localparam int MAX_WAIT      = 16;
	localparam int MAX_PRINTED   = 40;

	class tone_scoreboard;
		logic [AMP_W-1:0]  amp_scale;
		logic [GAP_W-1:0]  gap_cfg;
		logic [FADE_W-1:0] fade_cfg;
		logic [15:0]       phase;
		logic [LEN_W-1:0]  position;
		logic [LEN_W-1:0]  tone_len;
		logic [FADE_W-1:0] fade_len;
		logic [FREQ_W-1:0] tone_freq;
		logic [GAP_W-1:0]  gap_left;
		play_mode_t        mode;
		logic              gap_pending;
		tone_sample_t      expected_samples[$];
		int requests, starts, checked, seg_ends, reg_writes, errors;

		function void restore_reset();
			amp_scale   = AMP_RESET;
			gap_cfg     = GAP_RESET;
			fade_cfg    = FADE_RESET;
			phase       = '0;
			position    = '0;
			tone_len    = '0;
			fade_len    = FADE_W'(1);
			tone_freq   = '0;
			gap_left    = '0;
			mode        = MODE_IDLE;
			gap_pending = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			reg_writes++;
			case (idx)
			CFG_AMPLITUDE: amp_scale = data[AMP_W-1:0];
			CFG_GAP:       gap_cfg   = data[GAP_W-1:0];
			CFG_MAX_FADE:  fade_cfg  = data[FADE_W-1:0];
			default: ;
			endcase
		endfunction

		function void note_request(logic act, logic [FREQ_W-1:0] freq,
				logic [DUR_W-1:0] dur, logic last);
			int unsigned span, ramp, left, num, mag, nxt;
			tone_sample_t s;
			requests++;
			if (act == ACT_START) begin
				starts++;
				span = dur;
				span = span * SAMPLE_RATE / MS_PER_S;
				if (span < 1) span = 1;
				if (span > LEN_MAX) span = LEN_MAX;
				tone_len = LEN_W'(span);
				ramp = span / 4;
				if (ramp > fade_cfg) ramp = fade_cfg;
				if (ramp < 1) ramp = 1;
				fade_len    = FADE_W'(ramp);
				tone_freq   = FREQ_W'(freq % SAMPLE_RATE);
				phase       = '0;
				position    = '0;
				gap_left    = last ? '0 : gap_cfg;
				gap_pending = (gap_left != 0);
				mode        = MODE_TONE;
				return;
			end
			s.sample      = '0;
			s.active      = 1'b0;
			s.segment_end = 1'b0;
			case (mode)
			MODE_TONE: begin
				left = (position < tone_len) ? tone_len - position - 1 : 0;
				num = (position < left) ? position : left;
				if (num > fade_len) num = fade_len;
				mag = amp_scale;
				mag = mag * num / fade_len;
				if (phase < SAMPLE_RATE / 2) s.sample = SAMPLE_W'(mag);
				else s.sample = -SAMPLE_W'(mag);
				s.active = 1'b1;
				if (left == 0) begin
					if (gap_pending) mode = MODE_GAP;
					else begin
						mode = MODE_IDLE;
						s.segment_end = 1'b1;
					end
				end else begin
					position++;
				end
				nxt = phase + tone_freq;
				if (nxt >= SAMPLE_RATE) nxt -= SAMPLE_RATE;
				phase = 16'(nxt);
			end
			MODE_GAP: begin
				s.active = 1'b1;
				if (gap_left <= 1) begin
					gap_left      = '0;
					gap_pending   = 1'b0;
					mode          = MODE_IDLE;
					s.segment_end = 1'b1;
				end else begin
					gap_left--;
				end
			end
			default: ;
			endcase
			expected_samples = {expected_samples, s};
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= MAX_PRINTED) $display("MISMATCH %0d: %s", errors, msg);
		endtask

		task check_result(logic signed [SAMPLE_W-1:0] got_sample, logic got_active,
				logic got_end);
			tone_sample_t want;
			if (expected_samples.size() == 0) begin
				report_mismatch($sformatf("unexpected sample %0d active %0b end %0b",
					got_sample, got_active, got_end));
				return;
			end
			want = expected_samples.pop_front();
			checked++;
			if (want.segment_end) seg_ends++;
			if (got_sample !== want.sample)
				report_mismatch($sformatf("sample #%0d: value %0d, want %0d",
					checked, got_sample, want.sample));
			if (got_active !== want.active)
				report_mismatch($sformatf("sample #%0d: active %0b, want %0b",
					checked, got_active, want.active));
			if (got_end !== want.segment_end)
				report_mismatch($sformatf("sample #%0d: segment_end %0b, want %0b",
					checked, got_end, want.segment_end));
		endtask
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       req_valid;
	logic                       req_stall;
	logic                       action;
	logic [FREQ_W-1:0]          frequency;
	logic [DUR_W-1:0]           duration_ms;
	logic                       last_tone;
	logic                       res_valid;
	logic                       res_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       active;
	logic                       segment_end;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_data;

	tone_scoreboard board;
	bit             no_idle;
	int unsigned    hold_left;

	square_tone_envelope_generator u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#15_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Result side: hold stall for a drawn number of cycles after each sample.
	initial begin
		res_stall <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall) begin
				board.check_result(sample, active, segment_end);
				hold_left = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
				res_stall <= (hold_left != 0);
			end else if (hold_left != 0) begin
				hold_left--;
				if (hold_left == 0) res_stall <= 1'b0;
			end
		end
	end

	task automatic send_request(input logic act, input logic [FREQ_W-1:0] freq,
			input logic [DUR_W-1:0] dur, input logic last);
		int unsigned idle;
		idle = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
		if (idle != 0) begin
			req_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		req_valid   <= 1'b1;
		action      <= act;
		frequency   <= freq;
		duration_ms <= dur;
		last_tone   <= last;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		board.note_request(act, freq, dur, last);
	endtask

	task automatic send_tick();
		send_request(ACT_TICK, FREQ_W'($urandom_range(0, 32767)),
			DUR_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drop the request line and let the block drain before touching registers.
	task automatic settle();
		req_valid <= 1'b0;
		while (board.expected_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure_phase(input int phase_no);
		logic [AMP_W-1:0]  amp;
		logic [GAP_W-1:0]  gap;
		logic [FADE_W-1:0] fade;
		case (phase_no)
		0: begin
			amp  = '1;
			gap  = '0;
			fade = '1;
		end
		1: begin
			amp  = '0;
			gap  = '1;
			fade = '0;
		end
		2: begin
			amp  = AMP_W'(1);
			gap  = GAP_W'(1);
			fade = FADE_W'(1);
		end
		default: begin
			amp = AMP_W'($urandom_range(0, 32767));
			if ($urandom_range(0, 3) == 0) gap = GAP_W'($urandom_range(0, 1023));
			else gap = GAP_W'($urandom_range(0, 12));
			if ($urandom_range(0, 1) == 0) fade = FADE_W'($urandom_range(1, 8));
			else fade = FADE_W'($urandom_range(0, 255));
		end
		endcase
		write_reg(CFG_MAX_FADE, {7'($urandom_range(0, 127)), fade});
		write_reg(CFG_AMPLITUDE, amp);
		write_reg(CFG_GAP, {5'($urandom_range(0, 31)), gap});
		if (phase_no % 2 == 0) write_reg(CFG_UNUSED, CFG_W'($urandom));
	endtask

	task automatic play_tone(input int room, output int used);
		int pick, dur, span, ticks;
		logic last;
		pick = $urandom_range(0, 99);
		if (pick < 30) dur = 0;
		else if (pick < 70) dur = 1;
		else if (pick < 85) dur = $urandom_range(2, 3);
		else if (pick < 95) dur = $urandom_range(4, 40);
		else dur = $urandom_range(0, 4095);
		last = 1'($urandom_range(0, 1));
		span = dur * SAMPLE_RATE / MS_PER_S;
		if (span < 1) span = 1;
		ticks = span + (last ? 0 : int'(board.gap_cfg)) + $urandom_range(0, 2);
		if ($urandom_range(0, 4) == 0) ticks = $urandom_range(0, ticks);
		if (ticks > room - 1) ticks = room - 1;
		send_request(ACT_START, FREQ_W'($urandom_range(0, 32767)), DUR_W'(dur), last);
		repeat (ticks) send_tick();
		used = ticks + 1;
	endtask

	task automatic play_noise(input int room, output int used);
		used = $urandom_range(1, 4);
		if (used > room) used = room;
		repeat (used)
			send_request(1'($urandom_range(0, 1)), FREQ_W'($urandom_range(0, 32767)),
				DUR_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		int phase_no, budget, used, random_items;
		board = new;
		board.restore_reset();
		no_idle = 1'b0;
		arst_n      <= 1'b0;
		req_valid   <= 1'b0;
		action      <= ACT_TICK;
		frequency   <= '0;
		duration_ms <= '0;
		last_tone   <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(ACT_TICK, '1, '1, 1'b1);
		send_request(ACT_START, 15'd440, 12'd2, 1'b1);
		repeat (3) send_tick();
		settle();
		write_reg(CFG_AMPLITUDE, 15'h7fff);
		write_reg(CFG_GAP, 15'd3);
		write_reg(CFG_MAX_FADE, 15'd2);
		write_reg(CFG_UNUSED, 15'h7fff);
		send_request(ACT_START, '1, 12'd0, 1'b0);
		repeat (5) send_tick();
		send_request(ACT_START, '0, 12'd0, 1'b1);
		send_tick();
		send_request(ACT_START, 15'd22049, 12'd1, 1'b0);
		repeat (3) send_tick();
		send_request(ACT_START, 15'd11025, '1, 1'b1);
		repeat (3) send_tick();

		random_items = 0;
		phase_no = 0;
		while (random_items < RANDOM_ITEMS) begin
			settle();
			configure_phase(phase_no);
			budget = RANDOM_ITEMS - random_items;
			if (budget > PHASE_ITEMS) budget = PHASE_ITEMS;
			while (budget > 0) begin
				no_idle = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 9) == 0) play_noise(budget, used);
				else play_tone(budget, used);
				budget -= used;
				random_items += used;
			end
			phase_no++;
		end
		settle();

		$display("Covered %0d requests with %0d tone starts; %0d samples checked, %0d segment ends.",
			board.requests, board.starts, board.checked, board.seg_ends);
		$display("Wrote %0d registers across %0d register settings.",
			board.reg_writes, phase_no + 1);
		if (board.errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
